FILE: src/abf_pkg.sv
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types and constants for the allocation bitmap: opcodes, the row
// geometry of the flag RAM and the control and result bundles of the row unit.
// ----------------------------------------------------------------------------
package abf_pkg;

  localparam int ROW_W     = 64;  // flags per RAM row
  localparam int ROW_SEL_W = 6;   // bit select within a row
  localparam int FILL_W    = 7;   // 0..ROW_W valid flags in a row
  localparam int IDX_W     = 10;  // bit_index / found_index width
  localparam int CFG_W     = 11;  // bits_in_use width
  localparam int OP_W      = 3;

  localparam logic [CFG_W-1:0] BITS_IN_USE_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_TEST     = 3'd0,
    OP_SET      = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_FIND_CLR = 3'd3,
    OP_FIND_SET = 3'd4,
    OP_SET_ALL  = 3'd5,
    OP_CLR_ALL  = 3'd6
  } opcode_t;

  typedef struct packed {
    opcode_t              op;
    logic                 hit;     // this row holds the addressed flag, index in range
    logic [ROW_SEL_W-1:0] bit_sel;
    logic [FILL_W-1:0]    fill;    // flags of this row below the size in use
  } row_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0]     new_row;
    logic                 bit_value;
    logic                 match_any;
    logic [ROW_SEL_W-1:0] match_pos;
    logic                 any_set;
    logic                 any_clear;
  } row_res_t;

endpackage

FILE: src/allocation_bitmap_find_first.sv
// ----------------------------------------------------------------------------
// allocation_bitmap_find_first
// Bitmap allocator with test, set, clear, find-first and whole-map operations.
// ----------------------------------------------------------------------------
// The flags sit in a RAM of 64-bit rows, NUM_FLAGS/64 rows rounded up (16 for
// the default 1024 flags). Every opcode makes one pass over all rows, one row
// read per cycle through a single shared row unit that modifies the row, looks
// for the first match and folds in the all-set/all-clear status, so an item
// goes through the scan, drain and done states before the next is accepted;
// the single read port of the flag RAM is why the rows go one at a time. The
// result sits in an output register, so a pending result does not stop the
// next item being taken. After reset the RAM is swept to zero, one row per
// cycle, during which in_ready is low; configuration writes are taken at any
// time but must only change while the block is idle.
module allocation_bitmap_find_first #(
  parameter int NUM_FLAGS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [abf_pkg::CFG_W-1:0]   cfg_bits_in_use,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [abf_pkg::OP_W-1:0]    in_opcode,
  input  logic [abf_pkg::IDX_W-1:0]   in_bit_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_bit_value,
  output logic                        out_found,
  output logic [abf_pkg::IDX_W-1:0]   out_found_index,
  output logic                        out_all_clear,
  output logic                        out_all_set,
  output logic                        out_bad_index
);
  import abf_pkg::*;

  localparam int NUM_ROWS = (NUM_FLAGS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int NF_W     = $clog2(NUM_FLAGS + 1);
  localparam int SIZE_W   = (NF_W > CFG_W) ? NF_W : CFG_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    bits_in_use_r;
  opcode_t             op_r;
  logic [IDX_W-1:0]    idx_r;
  logic [ROW_AW-1:0]   rd_row_r;
  logic [ROW_AW-1:0]   proc_row_r;
  logic                proc_valid_r;
  logic                found_r;
  logic [IDX_W-1:0]    found_idx_r;
  logic                bitv_r;
  logic                any_set_r;
  logic                any_clr_r;

  logic                out_valid_r;
  logic                out_bit_value_r;
  logic                out_found_r;
  logic [IDX_W-1:0]    out_found_index_r;
  logic                out_all_clear_r;
  logic                out_all_set_r;
  logic                out_bad_index_r;

  logic [SIZE_W-1:0]   size_w;
  logic [SIZE_W-1:0]   base_w;
  logic [SIZE_W-1:0]   found_sum_w;
  logic                bad_w;
  logic                last_row_w;
  logic                out_free_w;
  logic                ram_wr_en;
  logic [ROW_AW-1:0]   ram_wr_addr;
  logic [ROW_W-1:0]    ram_wr_data;
  logic [ROW_W-1:0]    ram_rd_data;
  row_ctl_t            ctl;
  row_res_t            res;

  // size in use: register saturated to the store size
  always_comb begin
    if (SIZE_W'(bits_in_use_r) > SIZE_W'(NUM_FLAGS)) begin
      size_w = SIZE_W'(NUM_FLAGS);
    end else begin
      size_w = SIZE_W'(bits_in_use_r);
    end
    bad_w = ((op_r == OP_TEST) || (op_r == OP_SET) || (op_r == OP_CLEAR)) &&
            (SIZE_W'(idx_r) >= size_w);
    base_w      = SIZE_W'(proc_row_r) << ROW_SEL_W;
    found_sum_w = base_w + SIZE_W'(res.match_pos);
    last_row_w  = (rd_row_r == ROW_AW'(NUM_ROWS - 1));
    out_free_w  = !out_valid_r || out_ready;
  end

  always_comb begin
    ctl.op      = op_r;
    ctl.hit     = !bad_w && (SIZE_W'(proc_row_r) == SIZE_W'(idx_r >> ROW_SEL_W));
    ctl.bit_sel = idx_r[ROW_SEL_W-1:0];
    if (size_w <= base_w) begin
      ctl.fill = '0;
    end else if ((size_w - base_w) >= SIZE_W'(ROW_W)) begin
      ctl.fill = FILL_W'(ROW_W);
    end else begin
      ctl.fill = FILL_W'(size_w - base_w);
    end
  end

  always_comb begin
    ram_wr_en   = (state_r == ST_CLEAR) || proc_valid_r;
    ram_wr_addr = (state_r == ST_CLEAR) ? rd_row_r : proc_row_r;
    ram_wr_data = (state_r == ST_CLEAR) ? '0 : res.new_row;
  end

  abf_flag_ram #(
    .DEPTH  (NUM_ROWS),
    .ADDR_W (ROW_AW),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (rd_row_r),
    .rd_data (ram_rd_data)
  );

  abf_row_unit u_row (
    .ctl     (ctl),
    .old_row (ram_rd_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      bits_in_use_r <= BITS_IN_USE_RST;
      rd_row_r      <= '0;
      proc_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bits_in_use_r <= cfg_bits_in_use;
      end
      proc_valid_r <= (state_r == ST_SCAN);
      proc_row_r   <= rd_row_r;

      if (proc_valid_r) begin
        if (!found_r && res.match_any) begin
          found_r     <= 1'b1;
          found_idx_r <= found_sum_w[IDX_W-1:0];
        end
        if (res.bit_value) bitv_r    <= 1'b1;
        if (res.any_set)   any_set_r <= 1'b1;
        if (res.any_clear) any_clr_r <= 1'b1;
      end

      // in ST_DONE the output register is reloaded below instead
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          if (last_row_w) begin
            rd_row_r <= '0;
            state_r  <= ST_IDLE;
          end else begin
            rd_row_r <= rd_row_r + ROW_AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_r        <= opcode_t'(in_opcode);
            idx_r       <= in_bit_index;
            rd_row_r    <= '0;
            found_r     <= 1'b0;
            found_idx_r <= '0;
            bitv_r      <= 1'b0;
            any_set_r   <= 1'b0;
            any_clr_r   <= 1'b0;
            state_r     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_row_w) begin
            rd_row_r <= '0;
            state_r  <= ST_DRAIN;
          end else begin
            rd_row_r <= rd_row_r + ROW_AW'(1);
          end
        end
        ST_DRAIN: state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free_w) begin
            out_valid_r       <= 1'b1;
            out_bit_value_r   <= bitv_r;
            out_found_r       <= found_r;
            out_found_index_r <= found_idx_r;
            out_all_clear_r   <= !any_set_r;
            out_all_set_r     <= !any_clr_r;
            out_bad_index_r   <= bad_w;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_bit_value   = out_bit_value_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_found_index_r;
  assign out_all_clear   = out_all_clear_r;
  assign out_all_set     = out_all_set_r;
  assign out_bad_index   = out_bad_index_r;

endmodule

FILE: src/abf_flag_ram.sv
// ----------------------------------------------------------------------------
// abf_flag_ram
// Flag store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module abf_flag_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/abf_row_unit.sv
// ----------------------------------------------------------------------------
// abf_row_unit
// Shared row unit: applies the opcode to one 64-flag row, masks off flags past
// the size in use, priority-encodes the first match and reduces set/clear.
// ----------------------------------------------------------------------------
module abf_row_unit (
  input  abf_pkg::row_ctl_t        ctl,
  input  logic [abf_pkg::ROW_W-1:0] old_row,
  output abf_pkg::row_res_t        res
);
  import abf_pkg::*;

  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] one_hot;
  logic [ROW_W-1:0] new_row;
  logic [ROW_W-1:0] match;

  always_comb begin
    if (ctl.fill >= FILL_W'(ROW_W)) begin
      mask = '1;
    end else begin
      mask = (ROW_W'(1) << ctl.fill) - ROW_W'(1);
    end
    one_hot = ROW_W'(1) << ctl.bit_sel;

    new_row = old_row;
    match   = '0;
    case (ctl.op)
      OP_SET: begin
        if (ctl.hit) new_row = old_row | one_hot;
      end
      OP_CLEAR: begin
        if (ctl.hit) new_row = old_row & ~one_hot;
      end
      OP_SET_ALL:  new_row = '1;
      OP_CLR_ALL:  new_row = '0;
      OP_FIND_SET: match = old_row & mask;
      OP_FIND_CLR: match = ~old_row & mask;
      default: ;
    endcase
  end

  // lowest set bit wins
  always_comb begin
    res.match_pos = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (match[i]) res.match_pos = ROW_SEL_W'(i);
    end
    res.new_row   = new_row;
    res.match_any = |match;
    res.bit_value = ctl.hit && (ctl.op == OP_TEST) && old_row[ctl.bit_sel];
    res.any_set   = |(new_row & mask);
    res.any_clear = |(~new_row & mask);
  end

endmodule

FILE: src/abf_checker.sv
// ----------------------------------------------------------------------------
// abf_checker
// Port-level checks for the allocation bitmap, bound to the top level.
// ----------------------------------------------------------------------------
module abf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_bit_value,
  input logic                      out_found,
  input logic [abf_pkg::IDX_W-1:0] out_found_index,
  input logic                      out_bad_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_index) &&
                                $stable(out_found))
    else $error("result changed while stalled");

  // index reads zero when nothing was found
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == '0)
    else $error("found_index set without a match");

  // a bad index reports nothing else
  a_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> !out_found && !out_bit_value)
    else $error("bad_index together with a hit");

  // the sequencer is busy after each transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while scanning");

endmodule

bind allocation_bitmap_find_first abf_checker u_abf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_bit_value   (out_bit_value),
  .out_found       (out_found),
  .out_found_index (out_found_index),
  .out_bad_index   (out_bad_index)
);

FILE: verif/allocation_bitmap_find_first_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// allocation_bitmap_find_first_tb
// Self-checking bench for the allocation bitmap. The bench keeps a flag map
// of its own, works out the expected result of every accepted operation and
// compares each result transfer field by field. It runs a directed opening
// and then random phases over a range of sizes in use. The sender works in
// bursts with gaps, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module allocation_bitmap_find_first_tb;
  import abf_pkg::*;

  localparam int MAP_FLAGS = 1024;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             all_clear;
    logic             all_set;
    logic             bad_index;
  } flag_result_t;

  class flag_map_scoreboard;
    bit [MAP_FLAGS-1:0] flag_map;
    logic [CFG_W-1:0]   size_reg;
    flag_result_t       awaited[$];
    int                 errors;

    function new();
      flag_map = '0;
      size_reg = BITS_IN_USE_RST;
      errors   = 0;
    endfunction

    function int unsigned live_size();
      return (size_reg > MAP_FLAGS) ? MAP_FLAGS : size_reg;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_reg = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function flag_result_t apply_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
      flag_result_t r;
      int unsigned  size;
      int           i;
      bit           want;
      bit           any_set;
      bit           any_clear;
      r         = '0;
      size      = live_size();
      any_set   = 0;
      any_clear = 0;
      case (op)
        OP_TEST, OP_SET, OP_CLEAR: begin
          if (idx >= size) begin
            r.bad_index = 1'b1;
          end else if (op == OP_TEST) begin
            r.bit_value = flag_map[idx];
          end else begin
            flag_map[idx] = (op == OP_SET);
          end
        end
        OP_FIND_CLR, OP_FIND_SET: begin
          want = (op == OP_FIND_SET);
          for (i = 0; i < size; i++) begin
            if (!r.found && flag_map[i] == want) begin
              r.found       = 1'b1;
              r.found_index = 10'(i);
            end
          end
        end
        // whole-map writes reach past the size in use too
        OP_SET_ALL: flag_map = '1;
        OP_CLR_ALL: flag_map = '0;
        default: ;
      endcase
      for (i = 0; i < size; i++) begin
        if (flag_map[i]) any_set = 1;
        else any_clear = 1;
      end
      r.all_clear = !any_set;
      r.all_set   = !any_clear;
      return r;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
      awaited.push_back(apply_op(op, idx));
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(flag_result_t got);
      flag_result_t exp;
      if (awaited.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
        return;
      end
      exp = awaited.pop_front();
      if (got.bit_value !== exp.bit_value)
        report_mismatch($sformatf("bit_value %b, want %b", got.bit_value, exp.bit_value));
      if (got.found !== exp.found)
        report_mismatch($sformatf("found %b, want %b", got.found, exp.found));
      if (got.found_index !== exp.found_index)
        report_mismatch($sformatf("found_index %0d, want %0d",
                                  got.found_index, exp.found_index));
      if (got.all_clear !== exp.all_clear)
        report_mismatch($sformatf("all_clear %b, want %b", got.all_clear, exp.all_clear));
      if (got.all_set !== exp.all_set)
        report_mismatch($sformatf("all_set %b, want %b", got.all_set, exp.all_set));
      if (got.bad_index !== exp.bad_index)
        report_mismatch($sformatf("bad_index %b, want %b", got.bad_index, exp.bad_index));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_bits_in_use;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_opcode;
  logic [IDX_W-1:0] in_bit_index;
  logic             out_valid;
  logic             out_ready;
  logic             out_bit_value;
  logic             out_found;
  logic [IDX_W-1:0] out_found_index;
  logic             out_all_clear;
  logic             out_all_set;
  logic             out_bad_index;

  flag_map_scoreboard sb;
  int                 burst_left;
  int                 cycle_count;

  allocation_bitmap_find_first DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_bits_in_use (cfg_bits_in_use),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_bit_index    (in_bit_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bit_value   (out_bit_value),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_all_clear   (out_all_clear),
    .out_all_set     (out_all_set),
    .out_bad_index   (out_bad_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: stall pattern changes every span
  initial begin : receiver
    int stall_mode;
    int span;
    int k;
    out_ready = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      span       = $urandom_range(10, 120);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 7);
          2: out_ready <= (k % 4 != 0);
          default: out_ready <= (k % 40 == 39);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_bit_value, out_found, out_found_index,
                       out_all_clear, out_all_set, out_bad_index});
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    int gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_bit_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, idx);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 20);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // size register changes only with the block idle
  task automatic write_size(input logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_bits_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_size(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    int unsigned      size;
    int               pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    size = sb.live_size();
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = OP_TEST;
    else if (pick < 55) op = OP_SET;
    else if (pick < 75) op = OP_CLEAR;
    else if (pick < 83) op = OP_FIND_CLR;
    else if (pick < 91) op = OP_FIND_SET;
    else if (pick < 94) op = OP_SET_ALL;
    else if (pick < 97) op = OP_CLR_ALL;
    else                op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (size > 0 && pick < 70)
      idx = IDX_W'($urandom_range(0, size - 1));
    else if (size > 0 && pick < 80)
      idx = IDX_W'(($urandom_range(0, 1) == 1 && size < MAP_FLAGS) ? size : size - 1);
    else
      idx = IDX_W'($urandom_range(0, MAP_FLAGS - 1));
    send_op(op, idx);
  endtask

  initial begin : stimulus
    int phase_sizes[15];
    phase_sizes     = '{1, 2, 7, 8, 9, 63, 64, 65, 0, 1023, 1024, 2047, 1025, 100, 512};
    sb              = new();
    burst_left      = 0;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_bits_in_use = BITS_IN_USE_RST;
    in_valid        = 1'b0;
    in_opcode       = OP_TEST;
    in_bit_index    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening at the reset size
    send_op(OP_TEST, 10'd0);
    send_op(OP_SET, 10'd0);
    send_op(OP_SET, 10'd1023);
    send_op(OP_TEST, 10'd1023);
    send_op(OP_FIND_SET, 10'd0);
    send_op(OP_FIND_CLR, 10'd0);
    send_op(OP_CLEAR, 10'd0);
    send_op(OP_FIND_SET, 10'd0);
    send_op(OP_SET_ALL, 10'd0);
    send_op(OP_FIND_CLR, 10'd1023);
    send_op(OP_CLEAR, 10'd1023);
    send_op(OP_FIND_CLR, 10'd0);
    send_op(OP_CLR_ALL, 10'd0);
    send_op(OP_FIND_SET, 10'd0);
    send_op(OP_UNUSED, 10'd1023);
    // small map: out-of-range indices, then bits past the size after set all
    write_size(11'd8);
    send_op(OP_SET, 10'd7);
    send_op(OP_TEST, 10'd8);
    send_op(OP_SET, 10'd8);
    send_op(OP_FIND_SET, 10'd0);
    send_op(OP_SET_ALL, 10'd0);
    write_size(11'd16);
    send_op(OP_TEST, 10'd12);
    // no flag in use
    write_size(11'd0);
    send_op(OP_TEST, 10'd0);
    send_op(OP_FIND_CLR, 10'd0);
    send_op(OP_UNUSED, 10'd0);
    // oversize register saturates
    write_size(11'd2047);
    send_op(OP_FIND_SET, 10'd0);

    foreach (phase_sizes[p]) begin
      write_size(CFG_W'(phase_sizes[p]));
      repeat (120) send_random();
    end
    repeat (4) begin
      write_size(CFG_W'($urandom_range(1, MAP_FLAGS)));
      repeat (50) send_random();
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: allocation_bitmap_find_first.f
src/abf_pkg.sv
src/abf_flag_ram.sv
src/abf_row_unit.sv
src/allocation_bitmap_find_first.sv
src/abf_checker.sv
verif/allocation_bitmap_find_first_tb.sv
